/* rtl/rdcd_pkg.sv */
// shared types, constants and tables for the remote drive command decoder
package rdcd_pkg;

  // duty fraction width and the register port
  localparam int FRAC_BITS_DEFAULT = 12;
  localparam int CFG_W             = 13;
  localparam logic [CFG_W-1:0] AUTO_TURN_DUTY_RESET = 13'd1638;
  localparam int PADDR_W           = 3;
  localparam int PDATA_W           = 32;

  // command byte codes
  localparam logic [7:0] BYTE_ESC     = 8'd27;
  localparam logic [7:0] BYTE_BRACKET = 8'd91;
  localparam logic [7:0] KEY_UP       = 8'd65;
  localparam logic [7:0] KEY_DOWN     = 8'd66;
  localparam logic [7:0] KEY_RIGHT    = 8'd67;
  localparam logic [7:0] KEY_LEFT     = 8'd68;
  localparam logic [7:0] CMD_STOP     = 8'h73;
  localparam logic [7:0] CMD_FWD      = 8'h66;
  localparam logic [7:0] CMD_BACK     = 8'h62;
  localparam logic [7:0] CMD_MANUAL   = 8'h6d;
  localparam logic [7:0] CMD_AUTO     = 8'h61;

  // escape sequence recogniser states
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_CSI
  } phase_t;

  // drive state seen by the duty logic
  typedef struct packed {
    logic [1:0]        speed;
    logic signed [2:0] steer;
    logic              enable;
    logic              fwd;
    logic              auto_mode;
    logic              straight;
    logic              turn;
    logic              led;
  } drv_state_t;

  // speed level to tenths
  function automatic logic [3:0] speed_tenths(input logic [1:0] lvl);
    logic [3:0] t;
    case (lvl)
      2'd0:    t = 4'd0;
      2'd1:    t = 4'd3;
      2'd2:    t = 4'd7;
      default: t = 4'd10;
    endcase
    return t;
  endfunction

  // left wheel share of the steer level, tenths
  function automatic logic [3:0] steer_left_tenths(input logic signed [2:0] s);
    logic [3:0] t;
    case (s)
      -3'sd3:  t = 4'd0;
      -3'sd2:  t = 4'd4;
      -3'sd1:  t = 4'd7;
      3'sd1:   t = 4'd10;
      3'sd2:   t = 4'd10;
      3'sd3:   t = 4'd10;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  // right wheel share of the steer level, tenths
  function automatic logic [3:0] steer_right_tenths(input logic signed [2:0] s);
    logic [3:0] t;
    case (s)
      -3'sd3:  t = 4'd10;
      -3'sd2:  t = 4'd10;
      -3'sd1:  t = 4'd10;
      3'sd1:   t = 4'd7;
      3'sd2:   t = 4'd4;
      3'sd3:   t = 4'd0;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/rdcd_in_if.sv */
// input item channel: command byte or pwm tick with sensor flags
interface rdcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic       path_clear;
  logic       ir_left_hit;
  logic       ir_right_hit;

  modport source (output valid, mode, rx_byte, path_clear, ir_left_hit, ir_right_hit,
                  input ready);
  modport sink   (input valid, mode, rx_byte, path_clear, ir_left_hit, ir_right_hit,
                  output ready);
endinterface

/* rtl/rdcd_out_if.sv */
// result item channel: motor duties and drive status
interface rdcd_out_if #(
  parameter int FRAC_BITS = rdcd_pkg::FRAC_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   left_duty;
  logic [FRAC_BITS:0]   right_duty;
  logic                 dir_pin;
  logic                 led_level;
  logic                 auto_active;
  logic [1:0]           speed_now;
  logic signed [2:0]    steer_now;

  modport source (output valid, left_duty, right_duty, dir_pin, led_level, auto_active,
                  speed_now, steer_now, input ready);
  modport sink   (input valid, left_duty, right_duty, dir_pin, led_level, auto_active,
                  speed_now, steer_now, output ready);
endinterface

/* rtl/remote_drive_command_decoder_unit.sv */
// Remote drive command decoder: input register, decode and duty logic, result register.
// Each accepted item goes to the input register, then to the result register that drives res.
// One item per cycle while res.ready allows; a single decode pass lies between the registers.
// The input stage keeps taking items while a result waits, stopping only when both are full.
// Synchronous active-high reset clears the drive state, both valid flags and the register
// (auto_turn_duty back to 1638).
module remote_drive_command_decoder_unit #(
  parameter int FRAC_BITS = rdcd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  rdcd_in_if.sink                       cmd,
  rdcd_out_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdcd_pkg::PADDR_W-1:0]  paddr,
  input  logic [rdcd_pkg::PDATA_W-1:0]  pwdata,
  output logic [rdcd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam logic REG_AUTO_TURN_DUTY = 1'b0;

  logic [rdcd_pkg::CFG_W-1:0] auto_turn_duty;
  logic                       reg_idx_hi;

  logic       in_valid;
  logic       in_mode;
  logic [7:0] in_byte;
  logic       in_clear;
  logic       in_ir_l;
  logic       in_ir_r;
  logic       advance;

  rdcd_pkg::drv_state_t st_next;
  logic [FRAC_BITS:0]   left_c;
  logic [FRAC_BITS:0]   right_c;

  // register port
  assign pready     = 1'b1;
  assign reg_idx_hi = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_turn_duty <= rdcd_pkg::AUTO_TURN_DUTY_RESET;
    end else if (psel && penable && pwrite && (reg_idx_hi == REG_AUTO_TURN_DUTY)) begin
      auto_turn_duty <= pwdata[rdcd_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (reg_idx_hi == REG_AUTO_TURN_DUTY)
                ? rdcd_pkg::PDATA_W'(auto_turn_duty) : '0;

  // stage handshake
  assign advance   = !res.valid || res.ready;
  assign cmd.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_mode  <= cmd.mode;
      in_byte  <= cmd.rx_byte;
      in_clear <= cmd.path_clear;
      in_ir_l  <= cmd.ir_left_hit;
      in_ir_r  <= cmd.ir_right_hit;
    end
  end

  // byte decode and drive state
  rdcd_cmd_state u_state (
    .clk     (clk),
    .rst     (rst),
    .apply   (in_valid && advance),
    .is_byte (!in_mode),
    .rx_byte (in_byte),
    .st_next (st_next)
  );

  // duties from the updated state
  rdcd_duty #(
    .FRAC_BITS (FRAC_BITS)
  ) u_duty (
    .st             (st_next),
    .auto_turn_duty (auto_turn_duty),
    .path_clear     (in_clear),
    .ir_left_hit    (in_ir_l),
    .ir_right_hit   (in_ir_r),
    .left_duty      (left_c),
    .right_duty     (right_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res.left_duty   <= left_c;
      res.right_duty  <= right_c;
      res.dir_pin     <= st_next.enable && st_next.fwd;
      res.led_level   <= st_next.led;
      res.auto_active <= st_next.auto_mode;
      res.speed_now   <= st_next.speed;
      res.steer_now   <= st_next.steer;
    end
  end

endmodule

/* rtl/rdcd_cmd_state.sv */
// command byte decoder and drive state registers
module rdcd_cmd_state (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   apply,
  input  logic                   is_byte,
  input  logic [7:0]             rx_byte,
  output rdcd_pkg::drv_state_t   st_next
);

  rdcd_pkg::phase_t     phase;
  rdcd_pkg::phase_t     phase_next;
  rdcd_pkg::drv_state_t st;
  logic                 key_ok;

  // escape recogniser next state
  always_comb begin
    phase_next = phase;
    if (is_byte) begin
      case (rx_byte)
        rdcd_pkg::BYTE_ESC:     phase_next = rdcd_pkg::PH_ESC;
        rdcd_pkg::BYTE_BRACKET: begin
          if (phase == rdcd_pkg::PH_ESC) phase_next = rdcd_pkg::PH_CSI;
        end
        default:                phase_next = rdcd_pkg::PH_IDLE;
      endcase
    end
  end

  // arrow keys count only in the CSI phase, entered on ESC [
  assign key_ok = is_byte && (phase == rdcd_pkg::PH_CSI);

  // drive state update for the byte
  always_comb begin
    st_next = st;
    if (key_ok) begin
      case (rx_byte)
        rdcd_pkg::KEY_UP: begin
          st_next.enable = 1'b1;
          if (st.speed != 2'd3) st_next.speed = st.speed + 2'd1;
        end
        rdcd_pkg::KEY_DOWN: begin
          st_next.enable = 1'b1;
          if (st.speed != 2'd0) st_next.speed = st.speed - 2'd1;
        end
        rdcd_pkg::KEY_RIGHT: begin
          st_next.enable   = 1'b1;
          st_next.turn     = 1'b1;
          st_next.straight = 1'b0;
          if (st.steer < 3'sd3) st_next.steer = st.steer + 3'sd1;
        end
        rdcd_pkg::KEY_LEFT: begin
          st_next.enable   = 1'b1;
          st_next.turn     = 1'b1;
          st_next.straight = 1'b0;
          if (st.steer > -3'sd3) st_next.steer = st.steer - 3'sd1;
        end
        default: ;
      endcase
    end
    if (is_byte) begin
      case (rx_byte)
        rdcd_pkg::CMD_STOP: st_next.enable = 1'b0;
        rdcd_pkg::CMD_FWD: begin
          st_next.enable   = 1'b1;
          st_next.turn     = 1'b0;
          st_next.straight = 1'b1;
          st_next.fwd      = 1'b1;
        end
        rdcd_pkg::CMD_BACK: begin
          st_next.enable   = 1'b1;
          st_next.turn     = 1'b0;
          st_next.straight = 1'b1;
          st_next.fwd      = 1'b0;
        end
        rdcd_pkg::CMD_MANUAL: begin
          st_next.led       = 1'b1;
          st_next.enable    = 1'b1;
          st_next.auto_mode = 1'b0;
          st_next.fwd       = 1'b0;
          st_next.turn      = 1'b0;
          st_next.steer     = 3'sd0;
          st_next.speed     = 2'd0;
        end
        rdcd_pkg::CMD_AUTO: begin
          st_next.led       = 1'b0;
          st_next.enable    = 1'b1;
          st_next.auto_mode = 1'b1;
          st_next.fwd       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // state registers, updated as the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rdcd_pkg::PH_IDLE;
      st    <= '0;
    end else if (apply) begin
      phase <= phase_next;
      st    <= st_next;
    end
  end

endmodule

/* rtl/rdcd_duty.sv */
// wheel duty computation for manual and automatic drive
module rdcd_duty #(
  parameter int FRAC_BITS = rdcd_pkg::FRAC_BITS_DEFAULT
) (
  input  rdcd_pkg::drv_state_t        st,
  input  logic [rdcd_pkg::CFG_W-1:0]  auto_turn_duty,
  input  logic                        path_clear,
  input  logic                        ir_left_hit,
  input  logic                        ir_right_hit,
  output logic [FRAC_BITS:0]          left_duty,
  output logic [FRAC_BITS:0]          right_duty
);

  localparam int DUTY_W = FRAC_BITS + 1;
  localparam int CMP_W  = (DUTY_W > rdcd_pkg::CFG_W) ? DUTY_W : rdcd_pkg::CFG_W;

  // hundredths to duty fraction, truncated
  logic [DUTY_W-1:0] lut [0:127];
  for (genvar i = 0; i < 128; i++) begin : g_lut
    assign lut[i] = DUTY_W'((i * (1 << FRAC_BITS)) / 100);
  end

  logic [3:0]        sp;
  logic [3:0]        share [0:1];
  logic [7:0]        target [0:1];
  logic [7:0]        dir_h;
  logic [7:0]        diff [0:1];
  logic [6:0]        diff_sat [0:1];
  logic [DUTY_W-1:0] man [0:1];
  logic [CMP_W-1:0]  atd_ext;
  logic [CMP_W-1:0]  one_ext;
  logic [DUTY_W-1:0] atd_sat;

  assign sp       = rdcd_pkg::speed_tenths(st.speed);
  assign share[0] = rdcd_pkg::steer_left_tenths(st.steer);
  assign share[1] = rdcd_pkg::steer_right_tenths(st.steer);
  assign dir_h    = st.fwd ? 8'd100 : 8'd0;

  // manual lanes: |dir - target| in hundredths, saturated at one
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      target[w] = 8'd0;
      if (st.turn)     target[w] = target[w] + 8'(share[w]) * 8'(sp);
      if (st.straight) target[w] = target[w] + 8'(sp) * 8'd10;
      diff[w]     = (dir_h > target[w]) ? dir_h - target[w] : target[w] - dir_h;
      diff_sat[w] = (diff[w] > 8'd100) ? 7'd100 : diff[w][6:0];
      man[w]      = st.enable ? lut[diff_sat[w]] : '0;
    end
  end

  // automatic duty clipped to one
  assign atd_ext = CMP_W'(auto_turn_duty);
  assign one_ext = CMP_W'(1) << FRAC_BITS;
  assign atd_sat = (atd_ext > one_ext) ? DUTY_W'(one_ext) : DUTY_W'(atd_ext);

  // mode select
  always_comb begin
    if (st.auto_mode) begin
      left_duty  = (path_clear && ir_right_hit) ? atd_sat : '0;
      right_duty = (path_clear && ir_left_hit)  ? atd_sat : '0;
    end else begin
      left_duty  = man[0];
      right_duty = man[1];
    end
  end

endmodule

/* tb/rdcd_drive_checker.sv */
`timescale 1ns / 1ps
// drive decoder checker: watches both channels and the register port, predicts and compares
module rdcd_drive_checker
  import rdcd_pkg::*;
#(
  parameter int                 FRAC_BITS      = FRAC_BITS_DEFAULT,
  parameter logic [PADDR_W-1:0] TURN_DUTY_ADDR = '0
) (
  input  logic               clk,
  input  logic               rst,
  rdcd_in_if                 cmd,
  rdcd_out_if                res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 outstanding
);

  localparam int DUTY_ONE = 1 << FRAC_BITS;

  // share tables in tenths, entry 0 in the low nibble; steer tables indexed by level + 3
  localparam logic [15:0] SPEED_SHARE = {4'd10, 4'd7, 4'd3, 4'd0};
  localparam logic [27:0] LEFT_SHARE  = {4'd10, 4'd10, 4'd10, 4'd0, 4'd7, 4'd4, 4'd0};
  localparam logic [27:0] RIGHT_SHARE = {4'd0, 4'd4, 4'd7, 4'd0, 4'd10, 4'd10, 4'd10};

  typedef struct packed {
    logic [FRAC_BITS:0] left_duty;
    logic [FRAC_BITS:0] right_duty;
    logic               dir_pin;
    logic               led_level;
    logic               auto_active;
    logic [1:0]         speed_now;
    logic signed [2:0]  steer_now;
  } drive_result_t;

  logic [CFG_W-1:0] turn_duty;
  phase_t           esc_phase;
  drv_state_t       drv;
  drive_result_t    due_results[$];
  int               fail_count = 0;

  // apply one command byte: escape recogniser first, then the letter commands
  function automatic void take_command(input logic [7:0] b);
    if (b == BYTE_ESC) esc_phase = PH_ESC;
    if (b == BYTE_BRACKET && esc_phase == PH_ESC) esc_phase = PH_CSI;
    if (esc_phase == PH_CSI) begin
      case (b)
        KEY_UP: begin
          drv.enable = 1'b1;
          if (drv.speed != 2'd3) drv.speed = drv.speed + 2'd1;
        end
        KEY_DOWN: begin
          drv.enable = 1'b1;
          if (drv.speed != 2'd0) drv.speed = drv.speed - 2'd1;
        end
        KEY_RIGHT: begin
          drv.enable   = 1'b1;
          drv.turn     = 1'b1;
          drv.straight = 1'b0;
          if (drv.steer != 3'sd3) drv.steer = drv.steer + 3'sd1;
        end
        KEY_LEFT: begin
          drv.enable   = 1'b1;
          drv.turn     = 1'b1;
          drv.straight = 1'b0;
          if (drv.steer != -3'sd3) drv.steer = drv.steer - 3'sd1;
        end
        default: ;
      endcase
    end
    if (b != BYTE_ESC && b != BYTE_BRACKET) esc_phase = PH_IDLE;

    case (b)
      CMD_STOP: drv.enable = 1'b0;
      CMD_FWD: begin
        drv.enable   = 1'b1;
        drv.turn     = 1'b0;
        drv.straight = 1'b1;
        drv.fwd      = 1'b1;
      end
      CMD_BACK: begin
        drv.enable   = 1'b1;
        drv.turn     = 1'b0;
        drv.straight = 1'b1;
        drv.fwd      = 1'b0;
      end
      CMD_MANUAL: begin
        drv.led       = 1'b1;
        drv.enable    = 1'b1;
        drv.auto_mode = 1'b0;
        drv.fwd       = 1'b0;
        drv.turn      = 1'b0;
        drv.steer     = 3'sd0;
        drv.speed     = 2'd0;
      end
      CMD_AUTO: begin
        drv.led       = 1'b0;
        drv.enable    = 1'b1;
        drv.auto_mode = 1'b1;
        drv.fwd       = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // manual wheel duty: distance of the target from the direction level, in hundredths
  function automatic logic [FRAC_BITS:0] wheel_duty(input logic [3:0] share);
    int sp;
    int target;
    int level;
    int gap;
    int q;
    if (!drv.enable) return '0;
    sp     = int'(SPEED_SHARE[drv.speed*4 +: 4]);
    target = 0;
    if (drv.turn) target += int'(share) * sp;
    if (drv.straight) target += sp * 10;
    level = drv.fwd ? 100 : 0;
    gap   = (level > target) ? level - target : target - level;
    if (gap > 100) gap = 100;
    q = (gap * DUTY_ONE) / 100;
    return q[FRAC_BITS:0];
  endfunction

  // result item for the current state and the item's sensor flags
  function automatic drive_result_t predict_drive(input logic clear, input logic hit_l,
                                                  input logic hit_r);
    drive_result_t r;
    int            atd;
    int            idx;
    if (drv.auto_mode) begin
      atd          = (int'(turn_duty) > DUTY_ONE) ? DUTY_ONE : int'(turn_duty);
      r.left_duty  = (clear && hit_r) ? atd[FRAC_BITS:0] : '0;
      r.right_duty = (clear && hit_l) ? atd[FRAC_BITS:0] : '0;
    end else begin
      idx          = int'($signed(drv.steer)) + 3;
      r.left_duty  = wheel_duty(LEFT_SHARE[idx*4 +: 4]);
      r.right_duty = wheel_duty(RIGHT_SHARE[idx*4 +: 4]);
    end
    r.dir_pin     = drv.enable & drv.fwd;
    r.led_level   = drv.led;
    r.auto_active = drv.auto_mode;
    r.speed_now   = drv.speed;
    r.steer_now   = drv.steer;
    return r;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // results leave before new items join, as an accepted item is registered before it can leave
  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      turn_duty = AUTO_TURN_DUTY_RESET;
      esc_phase = PH_IDLE;
      drv       = '0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TURN_DUTY_ADDR)
        turn_duty = pwdata[CFG_W-1:0];
      if (res.valid && res.ready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $error("result item with no item waiting for it");
        end else begin
          want = due_results.pop_front();
          check_field("left_duty", int'(want.left_duty), int'(res.left_duty));
          check_field("right_duty", int'(want.right_duty), int'(res.right_duty));
          check_field("dir_pin", int'(want.dir_pin), int'(res.dir_pin));
          check_field("led_level", int'(want.led_level), int'(res.led_level));
          check_field("auto_active", int'(want.auto_active), int'(res.auto_active));
          check_field("speed_now", int'(want.speed_now), int'(res.speed_now));
          check_field("steer_now", int'($signed(want.steer_now)),
                      int'($signed(res.steer_now)));
        end
      end
      if (cmd.valid && cmd.ready) begin
        if (!cmd.mode) take_command(cmd.rx_byte);
        due_results.push_back(predict_drive(cmd.path_clear, cmd.ir_left_hit,
                                            cmd.ir_right_hit));
      end
    end
    errors      <= fail_count;
    outstanding <= due_results.size();
  end

endmodule

/* tb/remote_drive_command_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// testbench top for the remote drive command decoder: clock, reset, stimulus and verdict
module remote_drive_command_decoder_unit_tb;
  import rdcd_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_TURN_DUTY = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE     = 3'd4;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 385;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 5000;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int   fail_total;
  int   results_due;
  int   items_sent    = 0;
  int   settings_used = 1;
  int   quiet_cycles  = 0;
  logic calm_send     = 1'b0;
  logic hold_req      = 1'b0;

  rdcd_in_if  cmd ();
  rdcd_out_if res ();

  remote_drive_command_decoder_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rdcd_drive_checker #(
    .TURN_DUTY_ADDR (ADDR_TURN_DUTY)
  ) i_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .res         (res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .errors      (fail_total),
    .outstanding (results_due)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_arrow();
    case ($urandom_range(0, 5))
      0, 1, 2: return KEY_UP;
      3:       return KEY_DOWN;
      4:       return KEY_RIGHT;
      default: return KEY_LEFT;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 8))
      0:       return CMD_STOP;
      1, 2:    return CMD_FWD;
      3, 4:    return CMD_BACK;
      5, 6:    return CMD_MANUAL;
      7:       return CMD_AUTO;
      default: return CMD_STOP;
    endcase
  endfunction

  // offer one item after an optional gap and wait until it is taken
  task automatic send_item(input logic tick, input logic [7:0] b, input logic clear,
                           input logic hit_l, input logic hit_r);
    int gap;
    gap = calm_send ? 0 : pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.mode         <= tick;
    cmd.rx_byte      <= b;
    cmd.path_clear   <= clear;
    cmd.ir_left_hit  <= hit_l;
    cmd.ir_right_hit <= hit_r;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    items_sent++;
  endtask

  // same, with random sensor flags (path mostly clear)
  task automatic send_rand(input logic tick, input logic [7:0] b);
    logic [3:0] r;
    r = 4'($urandom_range(0, 15));
    send_item(tick, b, r[3] | r[2], r[1], r[0]);
  endtask

  // mostly well-formed arrow sequences and letters, some ticks, noise and broken escapes
  task automatic send_sequence();
    int         pick;
    logic [7:0] junk;
    pick = $urandom_range(0, 99);
    junk = 8'($urandom);
    if ($urandom_range(0, 199) == 0) calm_send = !calm_send;
    if (pick < 45) begin
      send_rand(1'b0, BYTE_ESC);
      send_rand(1'b0, BYTE_BRACKET);
      if (pick < 4) send_rand(1'b0, BYTE_BRACKET);
      else if (pick < 7) send_rand(1'b1, junk);
      send_rand(1'b0, pick_arrow());
    end else if (pick < 65) begin
      send_rand(1'b0, pick_letter());
    end else if (pick < 85) begin
      send_rand(1'b1, junk);
    end else if (pick < 91) begin
      send_rand(1'b0, junk);
    end else if (pick < 95) begin
      send_rand(1'b0, BYTE_ESC);
      send_rand(1'b0, junk);
    end else if (pick < 98) begin
      send_rand(1'b0, BYTE_ESC);
      send_rand(1'b0, BYTE_ESC);
      send_rand(1'b0, BYTE_BRACKET);
      send_rand(1'b0, pick_arrow());
    end else begin
      send_rand(1'b0, BYTE_BRACKET);
      send_rand(1'b0, pick_arrow());
    end
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop offering, wait for every result, then idle before returning
  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: random stalls, runs of steady ready, and one long hold-off on request
  initial begin
    int   n;
    logic held;
    held = 1'b0;
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        res.ready <= 1'b0;
        held = 1'b1;
        n = HOLD_CYCLES;
      end else if ($urandom_range(0, 7) == 0) begin
        res.ready <= 1'b1;
        n = $urandom_range(30, 80);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          res.ready <= 1'b1;
          n = $urandom_range(1, 6);
        end else begin
          res.ready <= 1'b0;
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence: reset, directed items, then random phases at several turn duties
  initial begin
    int          phase_end;
    logic [31:0] junk;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cmd.valid        <= 1'b0;
    cmd.mode         <= 1'b0;
    cmd.rx_byte      <= '0;
    cmd.path_clear   <= 1'b0;
    cmd.ir_left_hit  <= 1'b0;
    cmd.ir_right_hit <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, byte extremes, every command and arrow, auto with sensors
    send_item(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(1'b0, CMD_FWD, 1'b1, 1'b0, 1'b1);
    send_item(1'b0, BYTE_ESC, 1'b1, 1'b1, 1'b0);
    send_item(1'b0, BYTE_BRACKET, 1'b0, 1'b1, 1'b1);
    send_item(1'b0, KEY_UP, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, BYTE_ESC, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, BYTE_BRACKET, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, KEY_RIGHT, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, BYTE_ESC, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, BYTE_BRACKET, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, KEY_LEFT, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, BYTE_ESC, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, BYTE_BRACKET, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, KEY_DOWN, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, CMD_BACK, 1'b1, 1'b0, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, CMD_STOP, 1'b1, 1'b1, 1'b1);
    send_item(1'b0, CMD_AUTO, 1'b1, 1'b1, 1'b1);
    send_item(1'b1, 8'h00, 1'b1, 1'b1, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
    send_item(1'b0, CMD_MANUAL, 1'b1, 1'b1, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          reg_write(ADDR_TURN_DUTY, 32'd4096);
          reg_write(ADDR_SPARE, 32'd0);
        end
        1: begin
          reg_write(ADDR_TURN_DUTY, 32'd0);
          hold_req <= 1'b1;
        end
        2: begin
          junk = $urandom;
          reg_write(ADDR_TURN_DUTY, {junk[31:13], 13'h1FFF});
        end
        3:       reg_write(ADDR_TURN_DUTY, 32'd4097);
        default: reg_write(ADDR_TURN_DUTY, 32'($urandom_range(1, 4095)));
      endcase
      settings_used++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_sequence();
      drain();
    end

    $display("run covered %0d items: arrow sequences, letters, ticks and broken escapes,",
             items_sent);
    $display("under %0d turn duty settings incl. zero, full scale and above range",
             settings_used);
    if (fail_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
